/* hw/rtl/tile_background_sprite_pixel_macros.svh */
// assertion macros for the tile background sprite pixel block
// used by the port checker only
`ifndef TILE_BACKGROUND_SPRITE_PIXEL_MACROS_SVH
`define TILE_BACKGROUND_SPRITE_PIXEL_MACROS_SVH
// implication checked every clock, off during reset
`define TBS_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("check failed");
// next-cycle implication
`define TBS_ASSERT_NXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("check failed");
`endif

/* hw/rtl/tbsp_pkg.sv */
// shared types and constants for the tile background sprite pixel block
// no dependencies
package tbsp_pkg;
   localparam logic [1:0] REQ_VRAM_WRITE   = 2'd0;
   localparam logic [1:0] REQ_SPRITE_WRITE = 2'd1;
   localparam logic [1:0] REQ_RENDER       = 2'd2;

   localparam logic [2:0] CSR_LCD_CONTROL = 3'd0;
   localparam logic [2:0] CSR_SCROLL_Y    = 3'd1;
   localparam logic [2:0] CSR_SCROLL_X    = 3'd2;
   localparam logic [2:0] CSR_BG_PALETTE  = 3'd3;
   localparam logic [2:0] CSR_SPR_PAL0    = 3'd4;
   localparam logic [2:0] CSR_SPR_PAL1    = 3'd5;

   localparam logic [12:0] MAP_BASE_HI   = 13'h1C00;
   localparam logic [12:0] MAP_BASE_LO   = 13'h1800;
   localparam logic [12:0] SIGNED_BASE   = 13'h0800;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_RD,
      ST_MAP_WAIT,
      ST_BG_LO,
      ST_BG_HI,
      ST_BG_DONE,
      ST_SPR_RD,
      ST_SPR_EVAL,
      ST_SPR_LO,
      ST_SPR_HI,
      ST_SPR_DONE,
      ST_OUT
   } state_type;

   // palette lookup: colour index through palette to grey level
   function automatic logic [7:0] grey(input logic [7:0] pal, input logic [1:0] colour);
      logic [1:0] idx;
      idx = pal[colour*2 +: 2];
      unique case (idx)
         2'd0: grey = 8'd255;
         2'd1: grey = 8'd192;
         2'd2: grey = 8'd96;
         default: grey = 8'd0;
      endcase
   endfunction
endpackage

/* hw/rtl/tbsp_sprite_ram.sv */
// sprite attribute table: 4-byte entries, one 32-bit word per sprite
// uses tbsp_pkg only for style consistency of imports
module tbsp_sprite_ram #(
   parameter int SPRITE_COUNT = 40,
   localparam int IW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_index,
   input  logic [1:0]    wr_byte,
   input  logic [7:0]    wr_data,
   input  logic [IW-1:0] rd_index,
   output logic [31:0]   rd_data
);
   import tbsp_pkg::*;
   logic [7:0]  mem0 [SPRITE_COUNT];
   logic [7:0]  mem1 [SPRITE_COUNT];
   logic [7:0]  mem2 [SPRITE_COUNT];
   logic [7:0]  mem3 [SPRITE_COUNT];
   logic [31:0] rd_data_ff;

   // byte-lane write, registered word read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         unique case (wr_byte)
            2'd0: mem0[wr_index] <= wr_data;
            2'd1: mem1[wr_index] <= wr_data;
            2'd2: mem2[wr_index] <= wr_data;
            default: mem3[wr_index] <= wr_data;
         endcase
      end
      rd_data_ff <= {mem3[rd_index], mem2[rd_index], mem1[rd_index], mem0[rd_index]};
   end
   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/tile_background_sprite_pixel.sv */
// top level of the tile background sprite pixel block
// depends on tbsp_pkg and tbsp_sprite_ram
//
// channel   ports                                    transfer
// request   start, busy, req_type/addr/data/line/col start & !busy
// response  rsp_valid, rsp_pixel_shade              rsp_valid, one cycle
// config    csr_write, csr_index, csr_data           csr_write
//
// writes never set busy; a render holds busy through the background fetch and a
// walk over the sprite entries, with a tile fetch per covering sprite (the walk is
// skipped with sprites off or the column past the screen, and both fetches with
// the display off), reading the sprite table and the video memory through one read port each.
// reset restores register defaults; memories are not cleared.
// the receiver cannot stall: each result shows for one cycle.
module tile_background_sprite_pixel #(
   parameter int VIDEO_BYTES  = 8192,
   parameter int SPRITE_COUNT = 40,
   parameter int SCREEN_WIDTH = 160
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [12:0] req_addr,
   input  logic [7:0]  req_data,
   input  logic [7:0]  req_line,
   input  logic [7:0]  req_column,
   output logic        rsp_valid,
   output logic [7:0]  rsp_pixel_shade,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import tbsp_pkg::*;
   localparam int VW = $clog2(VIDEO_BYTES);
   localparam int IW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
   localparam int CW = $clog2(SPRITE_COUNT + 1);

   logic [7:0] lcd_ff, scy_ff, scx_ff, bgp_ff, sp0_ff, sp1_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_ff <= 8'd145; scy_ff <= 8'd0; scx_ff <= 8'd0;
         bgp_ff <= 8'd252; sp0_ff <= 8'd255; sp1_ff <= 8'd255;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LCD_CONTROL: lcd_ff <= csr_data;
            CSR_SCROLL_Y:    scy_ff <= csr_data;
            CSR_SCROLL_X:    scx_ff <= csr_data;
            CSR_BG_PALETTE:  bgp_ff <= csr_data;
            CSR_SPR_PAL0:    sp0_ff <= csr_data;
            CSR_SPR_PAL1:    sp1_ff <= csr_data;
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [7:0]  line_ff, column_ff, shade_ff, shade_in;
   logic [7:0]  lo_ff, lo_in;
   logic [12:0] taddr_ff, taddr_in;
   logic [2:0]  bit_ff, bit_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        pal_ff, pal_in, pri_ff, pri_in;

   // video memory, one read port and one write port
   logic [7:0]  vram [VIDEO_BYTES];
   logic [7:0]  vrd_ff;
   logic [12:0] vaddr;
   logic        vwe;
   logic        accept;
   assign accept = start && !busy;
   assign vwe = accept && req_type == REQ_VRAM_WRITE && {1'b0, req_addr} < 14'(VIDEO_BYTES);
   always_ff @(posedge clock) begin
      if (vwe) vram[req_addr[VW-1:0]] <= req_data;
      vrd_ff <= vram[vaddr[VW-1:0]];
   end

   // sprite table
   logic [31:0] srd;
   logic        swe;
   assign swe = accept && req_type == REQ_SPRITE_WRITE
                && {1'b0, req_addr} < 14'(4 * SPRITE_COUNT);
   tbsp_sprite_ram #(.SPRITE_COUNT(SPRITE_COUNT)) u_spr (
      .clock(clock), .wr_en(swe), .wr_index(IW'(req_addr[12:2])),
      .wr_byte(req_addr[1:0]), .wr_data(req_data),
      .rd_index(idx_ff[IW-1:0]), .rd_data(srd)
   );

   // background coordinates
   logic [7:0] bx, by;
   assign bx = column_ff + scx_ff;
   assign by = line_ff + scy_ff;

   // sprite evaluation from the fetched entry
   logic [7:0] sy, sx, dy, dx, tile;
   logic [4:0] height;
   logic [3:0] row;
   logic       hit;
   always_comb begin
      height = lcd_ff[2] ? 5'd16 : 5'd8;
      sy = srd[7:0] - 8'd16;
      sx = srd[15:8] - 8'd8;
      dy = line_ff - sy;
      dx = column_ff - sx;
      hit = line_ff >= sy && {1'b0, dy} < {4'd0, height}
            && column_ff >= sx && dx < 8'd8;
      row = dy[3:0];
      if (srd[30]) row = 4'(height - 5'd1) - dy[3:0];
      tile = srd[23:16];
      if (lcd_ff[2]) tile[0] = 1'b0;
   end

   logic [1:0] colour;
   assign colour = {vrd_ff[bit_ff], lo_ff[bit_ff]};

   // sequencer
   always_comb begin
      state_in = state_ff; shade_in = shade_ff; lo_in = lo_ff;
      taddr_in = taddr_ff; bit_in = bit_ff; idx_in = idx_ff;
      pal_in = pal_ff; pri_in = pri_ff; vaddr = taddr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_RENDER) begin
               state_in = ST_MAP_RD;
            end
         end
         ST_MAP_RD: begin
            if (!lcd_ff[7]) begin
               shade_in = 8'd0; state_in = ST_OUT;
            end else begin
               vaddr = (lcd_ff[3] ? MAP_BASE_HI : MAP_BASE_LO)
                       + {3'd0, by[7:3], bx[7:3]};
               state_in = ST_MAP_WAIT;
            end
         end
         ST_MAP_WAIT: begin
            if (lcd_ff[4]) taddr_in = {1'b0, vrd_ff, 4'd0} + {9'd0, by[2:0], 1'b0};
            else taddr_in = SIGNED_BASE + {1'b0, vrd_ff ^ 8'h80, 4'd0}
                            + {9'd0, by[2:0], 1'b0};
            bit_in = 3'd7 - bx[2:0];
            state_in = ST_BG_LO;
         end
         ST_BG_LO: begin
            vaddr = taddr_ff; taddr_in = taddr_ff + 13'd1; state_in = ST_BG_HI;
         end
         ST_BG_HI: begin
            vaddr = taddr_ff; lo_in = vrd_ff; state_in = ST_BG_DONE;
         end
         ST_BG_DONE: begin
            shade_in = grey(bgp_ff, colour);
            idx_in = '0;
            if (!lcd_ff[1] || {1'b0, column_ff} >= 9'(SCREEN_WIDTH)) state_in = ST_OUT;
            else state_in = ST_SPR_RD;
         end
         ST_SPR_RD: begin
            if (idx_ff == CW'(SPRITE_COUNT)) state_in = ST_OUT;
            else state_in = ST_SPR_EVAL;
         end
         ST_SPR_EVAL: begin
            taddr_in = {1'b0, tile, 4'd0} + {8'd0, row, 1'b0};
            bit_in = srd[29] ? dx[2:0] : 3'd7 - dx[2:0];
            pal_in = srd[28]; pri_in = srd[31];
            if (hit) state_in = ST_SPR_LO;
            else begin
               idx_in = idx_ff + 1'b1; state_in = ST_SPR_RD;
            end
         end
         ST_SPR_LO: begin
            vaddr = taddr_ff; taddr_in = taddr_ff + 13'd1; state_in = ST_SPR_HI;
         end
         ST_SPR_HI: begin
            vaddr = taddr_ff; lo_in = vrd_ff; state_in = ST_SPR_DONE;
         end
         ST_SPR_DONE: begin
            if (colour != 2'd0 && !(pri_ff && shade_ff != 8'd255))
               shade_in = grey(pal_ff ? sp1_ff : sp0_ff, colour);
            idx_in = idx_ff + 1'b1;
            state_in = ST_SPR_RD;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      shade_ff <= shade_in; lo_ff <= lo_in; taddr_ff <= taddr_in;
      bit_ff <= bit_in; idx_ff <= idx_in; pal_ff <= pal_in; pri_ff <= pri_in;
      if (accept) begin
         line_ff <= req_line; column_ff <= req_column;
      end
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_pixel_shade = shade_ff;
endmodule

/* hw/rtl/tbsp_checker.sv */
// port checker for the tile background sprite pixel block
// depends on the macro header and tbsp_pkg; bound to the top level
`include "tile_background_sprite_pixel_macros.svh"
module tbsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic [7:0] rsp_pixel_shade
);
   import tbsp_pkg::*;
   // a result is never shown on back-to-back clocks
   `TBS_ASSERT_NXT(a_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   // a render transfer makes the block busy
   `TBS_ASSERT_NXT(a_render_busy, clock, reset, start && !busy && req_type == REQ_RENDER, busy)
   // block is idle right after a result
   `TBS_ASSERT_NXT(a_idle_after, clock, reset, rsp_valid, !busy)
   // shade is one of the four greys
   `TBS_ASSERT_IMP(a_grey, clock, reset, rsp_valid,
      rsp_pixel_shade == 8'd255 || rsp_pixel_shade == 8'd192 ||
      rsp_pixel_shade == 8'd96 || rsp_pixel_shade == 8'd0)
endmodule

bind tile_background_sprite_pixel tbsp_checker u_tbsp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_type(req_type), .rsp_valid(rsp_valid), .rsp_pixel_shade(rsp_pixel_shade)
);
